// ----- rtl/gas_pkg.sv -----
// gas_pkg: shared types and constants for the grid path search block
// no dependencies
package gas_pkg;
    localparam int unsigned DEF_MAX_ROWS = 8;
    localparam int unsigned DEF_MAX_COLS = 8;
    localparam int unsigned COORD_W      = 3;
    localparam int unsigned DIM_W        = 4;
    localparam int unsigned WALL_W       = 64;
    localparam int unsigned COST_W       = 6;
    localparam int unsigned F_W          = 7;
    localparam int unsigned CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WALL_MAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

    // neighbor directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } query_t;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               found;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WALL_W-1:0]    data;
    } cfg_t;

    function automatic logic [COORD_W:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
        return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
    endfunction
endpackage

// ----- rtl/gas_if.sv -----
// gas_if: valid/ready channels, each carrying one payload type
// depends on gas_pkg for payload types
interface gas_query_if;
    logic            valid;
    logic            ready;
    gas_pkg::query_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gas_result_if;
    logic             valid;
    logic             ready;
    gas_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gas_cfg_if;
    logic          valid;
    logic          ready;
    gas_pkg::cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/grid_astar_path_search.sv -----
// Grid A* search over a wall map of up to MAX_ROWS x MAX_COLS cells. A query is accepted,
// then a clearing pass runs over every cell. Each expansion then makes a minimum scan, one
// read and one compare per cell on the single f-compare unit, then a pick, then a neighbor
// pass, one read and one check per direction. The expansion that picks the goal stops after
// the pick. The backtrack takes a store step and a parent read step per path cell, only a
// store step for the start cell. Output takes a wait step and an emit step per path cell
// while the result side is ready. The input is not ready while a query runs.
// Each path cell is one beat on the result channel, start first; an unreachable goal or an
// out-of-range coordinate gives one beat with found=0. Configuration writes are taken at any
// time and should be made only while no query is running.
// depends on gas_pkg and gas_if
module grid_astar_path_search #(
    parameter int unsigned MAX_ROWS = gas_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = gas_pkg::DEF_MAX_COLS
) (
    input  logic clk,
    input  logic rst_n,
    gas_query_if.sink    query,
    gas_result_if.source result,
    gas_cfg_if.sink      cfg
);
    import gas_pkg::*;

    localparam int unsigned NCELLS = MAX_ROWS * MAX_COLS;
    localparam int unsigned IDX_W  = $clog2(NCELLS);
    localparam int unsigned CNT_W  = IDX_W + 1;
    localparam int unsigned RC_W   = 2 * COORD_W;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_CLEAR = 12'b000000000010,
        ST_SCAN  = 12'b000000000100,
        ST_CMP   = 12'b000000001000,
        ST_PICK  = 12'b000000010000,
        ST_NBR   = 12'b000000100000,
        ST_CHK   = 12'b000001000000,
        ST_BACK  = 12'b000010000000,
        ST_STEP  = 12'b000100000000,
        ST_EMIT  = 12'b001000000000,
        ST_FAIL  = 12'b010000000000,
        ST_WAIT  = 12'b100000000000
    } state_t;

    // configuration registers
    logic [WALL_W-1:0] wall_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_reg   <= '0;
            width_reg  <= DIM_W'(8);
            height_reg <= DIM_W'(8);
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_WALL_MAP:    wall_reg   <= cfg.data.data;
                REG_GRID_WIDTH:  width_reg  <= cfg.data.data[DIM_W-1:0];
                REG_GRID_HEIGHT: height_reg <= cfg.data.data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    // effective dimensions
    logic [DIM_W-1:0] eff_w, eff_h;
    always_comb
    begin
        eff_w = (width_reg == '0) ? DIM_W'(1) :
                (width_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : width_reg;
        eff_h = (height_reg == '0) ? DIM_W'(1) :
                (height_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : height_reg;
    end

    // per-query stores
    logic [COST_W-1:0] cost_mem   [NCELLS];
    logic [RC_W-1:0]   parent_mem [NCELLS];
    logic [NCELLS-1:0] open_reg, closed_reg, seen_reg;
    logic [NCELLS-1:0] open_next, closed_next, seen_next;

    state_t             state_reg, state_next;
    query_t             q_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic               have_reg, have_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic [COORD_W-1:0] best_r_reg, best_r_next;
    logic [COORD_W-1:0] best_c_reg, best_c_next;
    logic [F_W-1:0]     bestf_reg, bestf_next;
    logic [COST_W-1:0]  bestg_reg, bestg_next;
    logic [1:0]         dir_reg, dir_next;
    logic [RC_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]   plen_reg, plen_next;
    logic [RC_W-1:0]    path_mem [NCELLS];
    logic [RC_W-1:0]    path_rd_reg;
    logic [COST_W-1:0]  cost_rd_reg;
    logic [RC_W-1:0]    parent_rd_reg;
    result_t            res_reg, res_next;
    logic               rvalid_reg, rvalid_next;

    function automatic logic [IDX_W-1:0] cell_of(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
        return IDX_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

    logic [IDX_W-1:0] s_idx, g_idx;
    logic [RC_W-1:0]  start_rc, goal_rc;
    assign s_idx    = cell_of(q_reg.start_row, q_reg.start_col);
    assign g_idx    = cell_of(q_reg.goal_row, q_reg.goal_col);
    assign start_rc = {q_reg.start_row, q_reg.start_col};
    assign goal_rc  = {q_reg.goal_row, q_reg.goal_col};

    // single f unit: cell under scan, its cost read in the previous cycle
    logic [IDX_W-1:0] scan_idx;
    logic [F_W-1:0]   scan_f;
    assign scan_idx = cnt_reg[IDX_W-1:0];
    assign scan_f   = F_W'(cost_rd_reg) + F_W'(abs_diff(row_reg, q_reg.goal_row))
                    + F_W'(abs_diff(col_reg, q_reg.goal_col));

    // neighbor under test
    logic [COORD_W:0]   nr, nc;
    logic               nb_ok;
    logic [IDX_W-1:0]   nb_idx;
    logic [COST_W-1:0]  tg;
    always_comb
    begin
        nr = {1'b0, best_r_reg};
        nc = {1'b0, best_c_reg};
        case (dir_reg)
            DIR_UP:    nr = {1'b0, best_r_reg} - 1'b1;
            DIR_DOWN:  nr = {1'b0, best_r_reg} + 1'b1;
            DIR_LEFT:  nc = {1'b0, best_c_reg} - 1'b1;
            DIR_RIGHT: nc = {1'b0, best_c_reg} + 1'b1;
            default:   ;
        endcase
        nb_idx = cell_of(nr[COORD_W-1:0], nc[COORD_W-1:0]);
        tg = (bestg_reg == '1) ? bestg_reg : bestg_reg + 1'b1;
        nb_ok = !nr[COORD_W] && !nc[COORD_W]
             && ({1'b0, nr} < {1'b0, eff_h}) && ({1'b0, nc} < {1'b0, eff_w})
             && !wall_reg[nb_idx] && !closed_reg[nb_idx]
             && (!seen_reg[nb_idx] || tg < cost_rd_reg);
    end

    // store read addresses
    logic [IDX_W-1:0] cost_raddr, cur_idx;
    assign cost_raddr = (state_reg == ST_NBR) ? nb_idx : scan_idx;
    assign cur_idx    = cell_of(cur_reg[RC_W-1:COORD_W], cur_reg[COORD_W-1:0]);

    logic q_bad;
    assign q_bad = ({1'b0, q_reg.start_row} >= eff_h) || ({1'b0, q_reg.start_col} >= eff_w)
                || ({1'b0, q_reg.goal_row} >= eff_h) || ({1'b0, q_reg.goal_col} >= eff_w);

    logic out_free;
    assign out_free = !rvalid_reg || result.ready;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        have_next   = have_reg;
        best_next   = best_reg;
        best_r_next = best_r_reg;
        best_c_next = best_c_reg;
        bestf_next  = bestf_reg;
        bestg_next  = bestg_reg;
        dir_next    = dir_reg;
        cur_next    = cur_reg;
        plen_next   = plen_reg;
        open_next   = open_reg;
        closed_next = closed_reg;
        seen_next   = seen_reg;
        res_next    = res_reg;
        rvalid_next = rvalid_reg && !result.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (query.valid)
                begin
                    state_next  = ST_CLEAR;
                    cnt_next    = '0;
                    open_next   = '0;
                    closed_next = '0;
                    seen_next   = '0;
                end
            end
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NCELLS - 1))
                begin
                    if (q_bad)
                        state_next = ST_FAIL;
                    else
                    begin
                        open_next[s_idx] = 1'b1;
                        seen_next[s_idx] = 1'b1;
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                        row_next   = '0;
                        col_next   = '0;
                        have_next  = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                // cost of the cell is read here, compared next cycle
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (open_reg[scan_idx] && (!have_reg || scan_f < bestf_reg))
                begin
                    have_next   = 1'b1;
                    best_next   = scan_idx;
                    best_r_next = row_reg;
                    best_c_next = col_reg;
                    bestf_next  = scan_f;
                    bestg_next  = cost_rd_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (col_reg == COORD_W'(MAX_COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                    col_next = col_reg + 1'b1;
                if (cnt_reg == CNT_W'(NCELLS - 1))
                    state_next = ST_PICK;
                else
                    state_next = ST_SCAN;
            end
            ST_PICK:
            begin
                if (!have_reg)
                    state_next = ST_FAIL;
                else
                begin
                    open_next[best_reg] = 1'b0;
                    if (best_reg == g_idx)
                    begin
                        cur_next   = goal_rc;
                        plen_next  = '0;
                        state_next = ST_BACK;
                    end
                    else
                    begin
                        closed_next[best_reg] = 1'b1;
                        dir_next   = DIR_UP;
                        state_next = ST_NBR;
                    end
                end
            end
            ST_NBR:
            begin
                // neighbor cost is read here, checked next cycle
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (nb_ok)
                begin
                    seen_next[nb_idx] = 1'b1;
                    open_next[nb_idx] = 1'b1;
                end
                dir_next = dir_reg + 1'b1;
                if (dir_reg == DIR_RIGHT)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    have_next  = 1'b0;
                end
                else
                    state_next = ST_NBR;
            end
            ST_BACK:
            begin
                // store the chain cell and read its parent
                plen_next = plen_reg + 1'b1;
                if (cur_reg == start_rc || plen_reg == CNT_W'(NCELLS - 1))
                    state_next = ST_WAIT;
                else
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cur_next   = parent_rd_reg;
                state_next = ST_BACK;
            end
            ST_WAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rvalid_next       = 1'b1;
                    res_next.cell_row = path_rd_reg[RC_W-1:COORD_W];
                    res_next.cell_col = path_rd_reg[COORD_W-1:0];
                    res_next.found    = 1'b1;
                    res_next.last     = (plen_reg == CNT_W'(1));
                    plen_next         = plen_reg - 1'b1;
                    state_next        = (plen_reg == CNT_W'(1)) ? ST_IDLE : ST_WAIT;
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    rvalid_next = 1'b1;
                    res_next    = '{cell_row: '0, cell_col: '0, found: 1'b0, last: 1'b1};
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
            open_reg   <= '0;
            closed_reg <= '0;
            seen_reg   <= '0;
            cnt_reg    <= '0;
            have_reg   <= 1'b0;
            plen_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            open_reg   <= open_next;
            closed_reg <= closed_next;
            seen_reg   <= seen_next;
            cnt_reg    <= cnt_next;
            have_reg   <= have_next;
            plen_reg   <= plen_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && query.valid)
            q_reg <= query.data;
        row_reg    <= row_next;
        col_reg    <= col_next;
        best_reg   <= best_next;
        best_r_reg <= best_r_next;
        best_c_reg <= best_c_next;
        bestf_reg  <= bestf_next;
        bestg_reg  <= bestg_next;
        dir_reg    <= dir_next;
        cur_reg    <= cur_next;
        res_reg    <= res_next;
    end

    // cost and parent stores, one write and registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            cost_mem[cnt_reg[IDX_W-1:0]] <= '0;
        else if (state_reg == ST_CHK && nb_ok)
        begin
            cost_mem[nb_idx]   <= tg;
            parent_mem[nb_idx] <= {best_r_reg, best_c_reg};
        end
        cost_rd_reg   <= cost_mem[cost_raddr];
        parent_rd_reg <= parent_mem[cur_idx];
    end

    // path stack: pushed goal first, popped start first
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BACK)
            path_mem[plen_reg[IDX_W-1:0]] <= (plen_reg == CNT_W'(NCELLS - 1)) ? start_rc
                                                                               : cur_reg;
        path_rd_reg <= path_mem[IDX_W'(plen_reg - 1'b1)];
    end

    assign query.ready = (state_reg == ST_IDLE);
    assign result.valid = rvalid_reg;
    assign result.data  = res_reg;

    // checks
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !query.ready)
        else $error("input taken during search");
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && !res_reg.found) |-> res_reg.last)
        else $error("not-found beat without last");
    a_start_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && state_next == ST_SCAN) |=> seen_reg[$past(s_idx)])
        else $error("start not seeded");
    a_closed_not_open: assert property (@(posedge clk) disable iff (!rst_n)
        (closed_reg & open_reg) == '0)
        else $error("cell both open and closed");
endmodule
